>>> hw/rtl/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  localparam int MaxPagesDefault = 16;

  localparam int SizeW   = 25;
  localparam int LimitW  = 5;
  localparam int OffsetW = 29;
  localparam int StatusW = 2;
  localparam int PageNumW = 5;
  localparam int CfgIndexW = 2;

  localparam logic [SizeW-1:0]  BaseSizeReset  = 25'd1048576;
  localparam logic [SizeW-1:0]  PageSizeReset  = 25'd1048576;
  localparam logic [LimitW-1:0] PageLimitReset = 5'd16;

  typedef enum logic [CfgIndexW-1:0] {
    REG_BASE_REGION_SIZE = 2'd0,
    REG_PAGE_SIZE        = 2'd1,
    REG_PAGE_LIMIT       = 2'd2
  } cfg_reg_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_GRANTED   = 2'd0,
    STATUS_OVERSIZE  = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/paged_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Paged bump allocator. A request is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high, and the receiver
// cannot stall it. A request that is oversized or fits the base region returns
// from the CHECK state. Otherwise the fill counters of the opened pages are
// read one per cycle from the page fill memory until one fits; if none fits, a
// new page is opened, or exhaustion is returned once the page limit is reached.
// The scan covers at most MAX_PAGES pages; the single read port of that memory
// sets its pace. Register writes take effect at once and keep all fills; write
// only while busy is low.
module paged_bump_allocator #(
  parameter int MAX_PAGES = pba_pkg::MaxPagesDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pba_pkg::SizeW-1:0]     request_size,
  input  wire logic                          cfg_write,
  input  wire logic [pba_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [pba_pkg::SizeW-1:0]     cfg_data,
  output logic                               done,
  output logic [pba_pkg::OffsetW-1:0]        offset,
  output logic [pba_pkg::SizeW-1:0]          granted_size,
  output logic [pba_pkg::StatusW-1:0]        status,
  output logic [pba_pkg::PageNumW-1:0]       page_number,
  output logic                               first_touch
);
  import pba_pkg::*;

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int LW = (CW > LimitW) ? CW : LimitW;
  localparam int PW = IW + SizeW;
  localparam int SW = (PW + 2 > OffsetW) ? PW + 2 : OffsetW;

  typedef enum logic [2:0] {
    IDLE, CHECK, SCAN, MULT, FINISH
  } state_t;

  state_t state;

  logic [SizeW-1:0]  base_region_size;
  logic [SizeW-1:0]  page_size;
  logic [LimitW-1:0] page_limit;

  logic [SizeW-1:0]  base_fill;
  logic [CW-1:0]     pages_open;
  logic [MAX_PAGES:0] page_touched;

  logic [SizeW-1:0]  req;
  logic [IW-1:0]     idx;
  logic [SizeW-1:0]  fill;
  logic [PW-1:0]     prod;

  logic [SizeW-1:0]  fill_mem [MAX_PAGES];
  logic [IW-1:0]     rd_addr;
  logic [SizeW-1:0]  rd_data;

  logic              base_fits;
  logic              page_fits;
  logic              more_pages;
  logic              limit_hit;
  logic [LW-1:0]     limit_eff;
  logic [CW-1:0]     page_sel;
  logic [SW-1:0]     offset_sum;

  assign busy = (state != IDLE);

  assign base_fits = ({1'b0, base_fill} + {1'b0, req}) <= {1'b0, base_region_size};
  assign page_fits = ({1'b0, rd_data} + {1'b0, req}) <= {1'b0, page_size};
  assign more_pages = (CW'(idx) + CW'(1)) < pages_open;
  assign limit_eff = (LW'(page_limit) > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(page_limit);
  assign limit_hit = LW'(pages_open) >= limit_eff;
  assign page_sel = CW'(idx) + CW'(1);
  assign offset_sum = SW'(base_region_size) + SW'(prod) + SW'(fill);
  assign rd_addr = (state == SCAN) ? idx + IW'(1) : '0;

  always_ff @(posedge clk) begin
    rd_data <= fill_mem[rd_addr];
    if (state == FINISH) begin
      fill_mem[idx] <= fill + req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_region_size <= BaseSizeReset;
      page_size        <= PageSizeReset;
      page_limit       <= PageLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_REGION_SIZE: base_region_size <= cfg_data;
        REG_PAGE_SIZE:        page_size        <= cfg_data;
        REG_PAGE_LIMIT:       page_limit       <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      base_fill    <= SizeW'(1);
      pages_open   <= '0;
      page_touched <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            req   <= request_size;
            state <= CHECK;
          end
        end
        CHECK: begin
          idx <= '0;
          if (req > page_size) begin
            done         <= 1'b1;
            offset       <= '0;
            granted_size <= req;
            status       <= STATUS_OVERSIZE;
            page_number  <= '0;
            first_touch  <= 1'b0;
            state        <= IDLE;
          end else if (base_fits) begin
            done         <= 1'b1;
            offset       <= OffsetW'(base_fill);
            granted_size <= req;
            status       <= STATUS_GRANTED;
            page_number  <= '0;
            first_touch  <= !page_touched[0];
            page_touched[0] <= 1'b1;
            base_fill    <= base_fill + req;
            state        <= IDLE;
          end else if (pages_open == '0) begin
            if (limit_hit) begin
              done         <= 1'b1;
              offset       <= '0;
              granted_size <= '0;
              status       <= STATUS_EXHAUSTED;
              page_number  <= '0;
              first_touch  <= 1'b0;
              state        <= IDLE;
            end else begin
              fill       <= '0;
              pages_open <= pages_open + CW'(1);
              state      <= MULT;
            end
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          priority if (page_fits) begin
            fill  <= rd_data;
            state <= MULT;
          end else if (more_pages) begin
            idx <= idx + IW'(1);
          end else if (limit_hit) begin
            done         <= 1'b1;
            offset       <= '0;
            granted_size <= '0;
            status       <= STATUS_EXHAUSTED;
            page_number  <= '0;
            first_touch  <= 1'b0;
            state        <= IDLE;
          end else begin
            idx        <= IW'(pages_open);
            fill       <= '0;
            pages_open <= pages_open + CW'(1);
            state      <= MULT;
          end
        end
        MULT: begin
          prod  <= PW'(idx) * PW'(page_size);
          state <= FINISH;
        end
        FINISH: begin
          done         <= 1'b1;
          offset       <= offset_sum[OffsetW-1:0];
          granted_size <= req;
          status       <= STATUS_GRANTED;
          page_number  <= PageNumW'(32'(page_sel));
          first_touch  <= !page_touched[page_sel];
          page_touched[page_sel] <= 1'b1;
          state        <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
